@@ hw/rtl/sobs_pkg.sv @@
// ----------------------------------------------------------------------------
// sobs_pkg
// Shared constants, types and helpers for the segmented odd-only bit sieve.
// ----------------------------------------------------------------------------
package sobs_pkg;

	localparam int SEGMENT_SPAN      = 8192;
	localparam int PRIME_TABLE_DEPTH = 4096;

	localparam int NUM_WORDS  = SEGMENT_SPAN / 128;
	localparam int NUM_BITS   = NUM_WORDS * 64;
	localparam int WORD_AW    = $clog2(NUM_WORDS);
	localparam int BIT_AW     = $clog2(NUM_BITS);
	localparam int TBL_AW     = $clog2(PRIME_TABLE_DEPTH);
	localparam int CNT_W      = TBL_AW + 1;
	localparam int START_W    = 45;
	localparam int TOP_W      = START_W + 1;
	localparam int PRIME_W    = 32;
	localparam int SEG_W      = 32;
	localparam int OUT_DATA_W = 120;

	typedef enum logic {
		ACT_LOAD  = 1'b0,
		ACT_SIEVE = 1'b1
	} action_t;

	typedef struct packed {
		action_t            action;
		logic [PRIME_W-1:0] base_prime;
		logic [SEG_W-1:0]   segment_index;
	} item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_FETCH,
		ST_TBL,
		ST_CHECK,
		ST_DIV,
		ST_OFFS,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

	function automatic logic [5:0] top_one(input logic [63:0] v);
		logic [5:0] r;
		r = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) r = 6'(i);
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/segmented_odd_bit_sieve.sv @@
// ----------------------------------------------------------------------------
// segmented_odd_bit_sieve
// Segmented odd-only sieve with a loadable base prime table.
// ----------------------------------------------------------------------------
// Input beats: tuser = action (0 load prime, 1 sieve segment), tdata holds
// base_prime and segment_index. Loads append to a 4096-entry table (extra
// loads dropped) and give no output. A sieve beat yields 64 output beats,
// one per 64-bit composite word, tlast on the final one, which also carries
// the largest unmarked odd number and its found flag.
// A load writes the table as it is dequeued. A sieve dequeues its beat, clears
// the bitmap, then for each odd table prime runs the bit-serial remainder unit
// and marks each multiple with a bitmap read-modify-write; even entries are
// skipped. It then emits the words, waiting while the receiver stalls. The
// walk stops at the first prime whose square exceeds the segment top, or when
// the table runs out.
// A two-beat input queue accepts beats while the engine is busy; the output
// register holds a beat while the receiver stalls and the engine waits.
// Reset empties the queue and clears the prime count; the table needs none.
// ----------------------------------------------------------------------------
module segmented_odd_bit_sieve (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [63:0]   s_axis_tdata,   // base_prime[31:0], segment_index[63:32]
	input  logic          s_axis_tuser,   // action[0]
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [119:0]  m_axis_tdata,   // word_index[5:0], composite_word[69:6],
	                                      // largest_prime[114:70], prime_found[115]
	output logic          m_axis_tlast
);
	import sobs_pkg::*;

	item_t in_item;
	item_t q_item;
	logic  q_valid;
	logic  q_pop;

	assign in_item.action        = action_t'(s_axis_tuser);
	assign in_item.base_prime    = s_axis_tdata[31:0];
	assign in_item.segment_index = s_axis_tdata[63:32];

	sobs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item)
	);

	sobs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

@@ hw/rtl/sobs_front.sv @@
// ----------------------------------------------------------------------------
// sobs_front
// Accepts input beats and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module sobs_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  sobs_pkg::item_t               in_item,
	output logic                          q_valid,
	input  logic                          q_pop,
	output sobs_pkg::item_t               q_item
);
	import sobs_pkg::*;

	item_t       mem_q [2];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic        pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

@@ hw/rtl/sobs_back.sv @@
// ----------------------------------------------------------------------------
// sobs_back
// Sieve engine: prime table, bitmap memory, remainder unit and word output.
// ----------------------------------------------------------------------------
module sobs_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	output logic                              q_pop,
	input  sobs_pkg::item_t                   q_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sobs_pkg::OUT_DATA_W-1:0]   out_data,
	output logic                              out_last
);
	import sobs_pkg::*;

	state_t               state_q, nxt;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     idx_q;
	logic [PRIME_W-1:0]   p_q;
	logic [63:0]          sq_q;
	logic [START_W-1:0]   start_q;
	logic [TOP_W-1:0]     top_q;
	logic [PRIME_W-1:0]   rem_q;
	logic [5:0]           dcnt_q;
	logic [PRIME_W:0]     k_q;
	logic [WORD_AW-1:0]   w_q;
	logic                 acc_found_q;
	logic [START_W-1:0]   acc_val_q;

	logic [PRIME_W-1:0]   tbl [PRIME_TABLE_DEPTH];
	logic [PRIME_W-1:0]   tbl_rd_q;
	logic [63:0]          bm [NUM_WORDS];
	logic [63:0]          bm_rd_q;

	logic                 ov_q;
	logic [5:0]           o_widx_q;
	logic [63:0]          o_word_q;
	logic                 o_last_q;
	logic [START_W-1:0]   o_largest_q;
	logic                 o_found_q;

	logic                 out_free;
	logic [PRIME_W:0]     trial;
	logic [PRIME_W:0]     d0;
	logic [PRIME_W:0]     d1;
	logic                 bm_we;
	logic [WORD_AW-1:0]   bm_wa;
	logic [63:0]          bm_wd;
	logic [WORD_AW-1:0]   bm_ra;
	logic                 bm_re;
	logic                 w_end;
	logic                 cur_found;
	logic [START_W-1:0]   cur_val;
	logic [START_W-1:0]   seg_base;

	assign out_free  = !ov_q || out_ready;
	assign out_valid = ov_q;
	assign out_last  = o_last_q;
	assign out_data  = {4'd0, o_found_q, o_largest_q, o_word_q, o_widx_q};
	assign w_end     = (w_q == WORD_AW'(NUM_WORDS - 1));

	assign trial = {rem_q, start_q[dcnt_q]};
	assign d0    = (rem_q == '0) ? '0 : {1'b0, p_q - rem_q};
	assign d1    = d0[0] ? d0 + {1'b0, p_q} : d0;

	assign cur_found = (~bm_rd_q != '0);
	assign cur_val   = start_q + START_W'({w_q, top_one(~bm_rd_q), 1'b0});
	assign seg_base  = START_W'({13'd0, q_item.segment_index} * 45'(SEGMENT_SPAN));

	always_comb begin
		nxt   = state_q;
		q_pop = 1'b0;
		bm_we = 1'b0;
		bm_wa = w_q;
		bm_wd = '0;
		bm_re = 1'b0;
		bm_ra = w_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_item.action == ACT_SIEVE) nxt = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				bm_we = 1'b1;
				if (w_end) nxt = ST_FETCH;
			end
			ST_FETCH: begin
				nxt = (idx_q == cnt_q) ? ST_EMIT_RD : ST_TBL;
			end
			ST_TBL: nxt = ST_CHECK;
			ST_CHECK: begin
				if (sq_q > 64'(top_q)) nxt = ST_EMIT_RD;
				else if (!p_q[0]) nxt = ST_FETCH;
				else nxt = ST_DIV;
			end
			ST_DIV: begin
				if (dcnt_q == '0) nxt = ST_OFFS;
			end
			ST_OFFS: nxt = ST_MARK_RD;
			ST_MARK_RD: begin
				if (k_q >= (PRIME_W+1)'(NUM_BITS)) begin
					nxt = ST_FETCH;
				end else begin
					bm_re = 1'b1;
					bm_ra = k_q[BIT_AW-1:6];
					nxt   = ST_MARK_WR;
				end
			end
			ST_MARK_WR: begin
				bm_we = 1'b1;
				bm_wa = k_q[BIT_AW-1:6];
				bm_wd = bm_rd_q | (64'd1 << k_q[5:0]);
				nxt   = ST_MARK_RD;
			end
			ST_EMIT_RD: begin
				bm_re = 1'b1;
				nxt   = ST_EMIT_WR;
			end
			ST_EMIT_WR: begin
				if (out_free) nxt = w_end ? ST_IDLE : ST_EMIT_RD;
			end
			default: nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid && q_item.action == ACT_LOAD
				&& cnt_q < CNT_W'(PRIME_TABLE_DEPTH))
			tbl[cnt_q[TBL_AW-1:0]] <= q_item.base_prime;
		if (state_q == ST_FETCH) tbl_rd_q <= tbl[idx_q[TBL_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (bm_we) bm[bm_wa] <= bm_wd;
		if (bm_re) bm_rd_q <= bm[bm_ra];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				start_q <= seg_base + START_W'(1);
				top_q   <= TOP_W'(seg_base) + TOP_W'(SEGMENT_SPAN - 1);
			end
			ST_TBL: begin
				p_q  <= tbl_rd_q;
				sq_q <= 64'(tbl_rd_q) * 64'(tbl_rd_q);
			end
			ST_CHECK: begin
				rem_q  <= '0;
				dcnt_q <= 6'(START_W - 1);
			end
			ST_DIV: begin
				rem_q  <= (trial >= {1'b0, p_q}) ? PRIME_W'(trial - {1'b0, p_q})
				                                 : trial[PRIME_W-1:0];
				dcnt_q <= dcnt_q - 6'd1;
			end
			ST_OFFS: k_q <= {1'b0, d1[PRIME_W:1]};
			ST_MARK_WR: k_q <= k_q + {1'b0, p_q};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			w_q         <= '0;
			acc_found_q <= 1'b0;
			acc_val_q   <= '0;
			ov_q        <= 1'b0;
			o_widx_q    <= '0;
			o_word_q    <= '0;
			o_last_q    <= 1'b0;
			o_largest_q <= '0;
			o_found_q   <= 1'b0;
		end else begin
			state_q <= nxt;
			if (out_ready && state_q != ST_EMIT_WR) ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					w_q         <= '0;
					idx_q       <= '0;
					acc_found_q <= 1'b0;
					acc_val_q   <= '0;
					if (q_valid && q_item.action == ACT_LOAD
							&& cnt_q < CNT_W'(PRIME_TABLE_DEPTH))
						cnt_q <= cnt_q + CNT_W'(1);
				end
				ST_CLEAR: w_q <= w_q + WORD_AW'(1);
				ST_CHECK: if (!(sq_q > 64'(top_q)) && !p_q[0]) idx_q <= idx_q + CNT_W'(1);
				ST_MARK_RD: begin
					if (k_q >= (PRIME_W+1)'(NUM_BITS)) idx_q <= idx_q + CNT_W'(1);
				end
				ST_EMIT_WR: begin
					if (out_free) begin
						ov_q     <= 1'b1;
						o_widx_q <= 6'(w_q);
						o_word_q <= bm_rd_q;
						o_last_q <= w_end;
						if (cur_found) begin
							acc_found_q <= 1'b1;
							acc_val_q   <= cur_val;
						end
						if (w_end) begin
							o_found_q   <= cur_found || acc_found_q;
							o_largest_q <= cur_found ? cur_val : acc_val_q;
						end else begin
							o_found_q   <= 1'b0;
							o_largest_q <= '0;
						end
						w_q <= w_q + WORD_AW'(1);
					end else if (out_ready) begin
						ov_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

@@ tb/sv/segmented_odd_bit_sieve_tb.sv @@
// ----------------------------------------------------------------------------
// segmented_odd_bit_sieve_tb
// Streams prime loads and segment sieves into the block, predicts each
// segment's composite bitmap and largest unmarked number, and checks every
// output beat in order under several idle and stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segmented_odd_bit_sieve_tb;
	import sobs_pkg::*;

	localparam int WDOG_LIMIT = 300000;
	localparam int HOLD_CYCLES = 3000;

	typedef struct packed {
		logic [5:0]  idx;
		logic [63:0] word;
		logic        last;
		logic [44:0] largest;
		logic        found;
	} bitmap_beat_t;

	typedef struct {
		action_t     act;
		logic [31:0] val;
		bit          typed;
		logic [44:0] t_largest;
		bit          t_found;
	} stim_row_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [63:0]   s_axis_tdata = '0;
	logic          s_axis_tuser = 1'b0;
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [119:0]  m_axis_tdata;
	logic          m_axis_tlast;

	logic [31:0]   base_tbl [PRIME_TABLE_DEPTH];
	int            base_cnt = 0;
	bitmap_beat_t  bitmap_q [$];
	int            err_cnt = 0;
	int            send_gap_pct = 0;
	int            recv_stall_pct = 0;
	bit            hold_req = 1'b0;
	int            quiet_cycles = 0;

	stim_row_t     directed [14];

	always #5 clk = ~clk;

	segmented_odd_bit_sieve i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	function automatic void sieve_predict(input logic [31:0] seg);
		longint unsigned start, top, p, j, k, largest;
		logic [63:0]     bm [NUM_WORDS];
		bit              found;
		bitmap_beat_t    b;
		start = 64'(seg) * 64'(SEGMENT_SPAN) + 64'd1;
		top = start + 64'(SEGMENT_SPAN) - 64'd2;
		foreach (bm[w]) bm[w] = '0;
		for (int i = 0; i < base_cnt; i++) begin
			p = 64'(base_tbl[i]);
			if (p * p > top) break;
			if (p[0] == 1'b0) continue;
			j = (start / p) * p;
			if (j < start) j += p;
			if (j[0] == 1'b0) j += p;
			for (; j <= top; j += p << 1) begin
				k = (j - start) >> 1;
				if (k < NUM_BITS) bm[k >> 6][k & 63] = 1'b1;
			end
		end
		found = 1'b0;
		largest = 0;
		for (int n = NUM_BITS - 1; n >= 0; n--) begin
			if (!bm[n >> 6][n & 63]) begin
				found = 1'b1;
				largest = start + (64'(n) << 1);
				break;
			end
		end
		for (int w = 0; w < NUM_WORDS; w++) begin
			b.idx = 6'(w);
			b.word = bm[w];
			b.last = (w == NUM_WORDS - 1);
			b.largest = b.last && found ? 45'(largest) : '0;
			b.found = b.last && found;
			bitmap_q.push_back(b);
		end
	endfunction

	task automatic send_item(input action_t act, input logic [31:0] val, input bit typed = 0,
	                         input logic [44:0] t_largest = '0, input bit t_found = 0);
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tuser = act;
		s_axis_tdata = (act == ACT_LOAD) ? {$urandom(), val} : {val, $urandom()};
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (act == ACT_LOAD) begin
			if (base_cnt < PRIME_TABLE_DEPTH) begin
				base_tbl[base_cnt] = val;
				base_cnt++;
			end
		end else begin
			sieve_predict(val);
			if (typed) begin
				bitmap_q[$].largest = t_largest;
				bitmap_q[$].found = t_found;
			end
		end
	endtask

	task automatic random_items(input int n);
		logic [31:0] v;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 45) begin
				case ($urandom_range(9))
					0: v = $urandom_range(4095);
					1, 2: v = $urandom_range(4095) | 32'd1;
					default: v = $urandom_range(3, 63) | 32'd1;
				endcase
				send_item(ACT_LOAD, v);
			end else begin
				v = ($urandom_range(99) < 30) ? $urandom_range(3) : $urandom();
				send_item(ACT_SIEVE, v);
			end
		end
	endtask

	// receiver: random stall per cycle, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		bitmap_beat_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (bitmap_q.size() == 0) begin
				$error("unexpected beat: word_index %0d", m_axis_tdata[5:0]);
				err_cnt++;
			end else begin
				e = bitmap_q.pop_front();
				if (m_axis_tdata[5:0] !== e.idx) begin
					$error("word_index: exp %0d got %0d", e.idx, m_axis_tdata[5:0]);
					err_cnt++;
				end
				if (m_axis_tdata[69:6] !== e.word) begin
					$error("composite_word: exp %h got %h", e.word, m_axis_tdata[69:6]);
					err_cnt++;
				end
				if (m_axis_tlast !== e.last) begin
					$error("last: exp %0b got %0b", e.last, m_axis_tlast);
					err_cnt++;
				end
				if (m_axis_tdata[114:70] !== e.largest) begin
					$error("largest_prime: exp %0d got %0d", e.largest, m_axis_tdata[114:70]);
					err_cnt++;
				end
				if (m_axis_tdata[115] !== e.found) begin
					$error("prime_found: exp %0b got %0b", e.found, m_axis_tdata[115]);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		directed = '{
			'{ACT_SIEVE, 32'd0,          1, 45'd8191, 1},
			'{ACT_LOAD,  32'd3,          0, '0, 0},
			'{ACT_LOAD,  32'd5,          0, '0, 0},
			'{ACT_LOAD,  32'd7,          0, '0, 0},
			'{ACT_LOAD,  32'd0,          0, '0, 0},
			'{ACT_LOAD,  32'd4,          0, '0, 0},
			'{ACT_LOAD,  32'd11,         0, '0, 0},
			'{ACT_LOAD,  32'd13,         0, '0, 0},
			'{ACT_SIEVE, 32'd0,          0, '0, 0},
			'{ACT_SIEVE, 32'd1,          0, '0, 0},
			'{ACT_SIEVE, 32'hFFFF_FFFF,  0, '0, 0},
			'{ACT_LOAD,  32'd97,         0, '0, 0},
			'{ACT_SIEVE, 32'd0,          0, '0, 0},
			'{ACT_SIEVE, 32'd2,          0, '0, 0}
		};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		hold_req = 1'b1;

		foreach (directed[r])
			send_item(directed[r].act, directed[r].val, directed[r].typed,
			          directed[r].t_largest, directed[r].t_found);

		send_gap_pct = 0;  recv_stall_pct = 0;  random_items(25);
		send_gap_pct = 84; recv_stall_pct = 0;  random_items(25);
		send_gap_pct = 0;  recv_stall_pct = 84; random_items(25);
		send_gap_pct = 13; recv_stall_pct = 13; random_items(25);

		// entry one marks the whole segment, a huge entry ends later walks early
		send_gap_pct = 0; recv_stall_pct = 0;
		send_item(ACT_LOAD, 32'd1);
		send_item(ACT_SIEVE, 32'hFFFF_FFFF, 1, '0, 0);
		send_item(ACT_LOAD, 32'hFFFF_FFFF);
		repeat (4) send_item(ACT_LOAD, $urandom());
		send_item(ACT_SIEVE, $urandom());

		@(negedge clk);
		s_axis_tvalid = 1'b0;
		wait (bitmap_q.size() == 0);
		repeat (200) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
